### hw/rtl/midpoint_circle_rasterizer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the midpoint circle rasterizer
// Concurrent checks clocked on the rising edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_CIRCLE_RASTERIZER_UNIT_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// prop must hold at every edge out of reset
`define MCRU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// cond must never be true out of reset
`define MCRU_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define MCRU_ASSERT(lbl, clk, rst_n, prop, msg)
`define MCRU_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### hw/rtl/mcru_pkg.sv
// ----------------------------------------------------------------------------
// mcru_pkg
// Shared types and constants of the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcru_pkg;

  // Item kind on the input channel
  typedef enum logic {
    KIND_START = 1'b0,
    KIND_NEXT  = 1'b1
  } kind_t;

  localparam int SHIFT_BITS = 8;

  // Eight symmetric points per step
  localparam int                  NUM_POINTS = 8;
  localparam int                  IDX_BITS   = 3;
  localparam logic [IDX_BITS-1:0] LAST_IDX   = IDX_BITS'(NUM_POINTS - 1);

  // Decision variable constants: init 3 - 2r, then +4x+6 or +4(x-y)+10
  localparam int DEC_INIT  = 3;
  localparam int INC_PLAIN = 6;
  localparam int INC_DIAG  = 10;

  // Step engine to serializer handoff
  typedef struct packed {
    logic load;  // a new step record is presented
    logic done;  // it is the final step of the circle
  } step_ctl_t;

endpackage

### hw/rtl/midpoint_circle_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit
// Midpoint circle rasterizer: eight symmetric points per step item.
// ----------------------------------------------------------------------------
//
//   channel  handshake            payload
//   -------  -------------------  ------------------------------------------
//   in       in_valid / in_ready  in_kind, in_center_x, in_center_y,
//                                 in_radius, in_shift
//   out      out_valid/out_ready  out_point_x, out_point_y,
//                                 out_last_of_step, out_circle_done
//
// Points: a step yields eight points, one per out transfer; the single output
//   register sets this pace.
// Path: in transfer, then the input register, the step buffer and the output register.
// A next item with no circle in progress leaves the input register as soon
//   as the step buffer is free and yields nothing.
// Reset: synchronous, active low; clears the valid flags and the circle
//   state. No memories, so no clearing pass.
// Stalls: out_ready low holds the output point; the input register still
//   takes one item while the step buffer is busy.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_unit import mcru_pkg::*; #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic signed [COORD_BITS-1:0]  in_center_x,
  input  logic signed [COORD_BITS-1:0]  in_center_y,
  input  logic        [RADIUS_BITS-1:0] in_radius,
  input  logic signed [SHIFT_BITS-1:0]  in_shift,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_BITS:0]    out_point_x,
  output logic signed [COORD_BITS:0]    out_point_y,
  output logic                          out_last_of_step,
  output logic                          out_circle_done
);

  // Input register
  logic                          in_vld_r;
  logic                          in_kind_r;
  logic signed [COORD_BITS-1:0]  in_cx_r, in_cy_r;
  logic        [RADIUS_BITS-1:0] in_rad_r;
  logic signed [SHIFT_BITS-1:0]  in_sh_r;

  logic                          sb_free, go, in_xfer;
  step_ctl_t                     ctl;
  logic signed [RADIUS_BITS:0]   cur_x, cur_y;
  logic signed [COORD_BITS:0]    cur_ox, cur_oy;

  // The buffered item moves on once the step buffer can take its step
  assign go       = in_vld_r && sb_free;
  assign in_ready = !in_vld_r || sb_free;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_kind_r <= in_kind;
      in_cx_r   <= in_center_x;
      in_cy_r   <= in_center_y;
      in_rad_r  <= in_radius;
      in_sh_r   <= in_shift;
    end
  end

  // Decision update and circle state
  mcru_step #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .kind     (kind_t'(in_kind_r)),
    .center_x (in_cx_r),
    .center_y (in_cy_r),
    .radius   (in_rad_r),
    .shift    (in_sh_r),
    .ctl      (ctl),
    .cur_x    (cur_x),
    .cur_y    (cur_y),
    .cur_ox   (cur_ox),
    .cur_oy   (cur_oy)
  );

  // Eight-point serializer with the output register
  mcru_serial #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_serial (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .x                (cur_x),
    .y                (cur_y),
    .ox               (cur_ox),
    .oy               (cur_oy),
    .sb_free          (sb_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_last_of_step (out_last_of_step),
    .out_circle_done  (out_circle_done)
  );

endmodule

### hw/rtl/mcru_step.sv
// ----------------------------------------------------------------------------
// mcru_step
// Circle state and one midpoint decision update per item.
// ----------------------------------------------------------------------------
module mcru_step import mcru_pkg::*; #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  kind_t                         kind,
  input  logic signed [COORD_BITS-1:0]  center_x,
  input  logic signed [COORD_BITS-1:0]  center_y,
  input  logic        [RADIUS_BITS-1:0] radius,
  input  logic signed [SHIFT_BITS-1:0]  shift,
  output step_ctl_t                     ctl,
  output logic signed [RADIUS_BITS:0]   cur_x,
  output logic signed [RADIUS_BITS:0]   cur_y,
  output logic signed [COORD_BITS:0]    cur_ox,
  output logic signed [COORD_BITS:0]    cur_oy
);

  localparam int STEP_BITS = RADIUS_BITS + 1;
  localparam int DEC_BITS  = RADIUS_BITS + 6;
  localparam int ORG_BITS  = COORD_BITS + 1;

  logic signed [STEP_BITS-1:0] step_x_r, step_y_r;
  logic signed [DEC_BITS-1:0]  dec_r;
  logic signed [ORG_BITS-1:0]  org_x_r, org_y_r;
  logic                        active_r;

  logic                        is_start;
  logic signed [DEC_BITS-1:0]  cur_d, x_d, y_d, dec_nxt;
  logic signed [STEP_BITS-1:0] step_x_nxt, step_y_nxt;
  logic                        dec_neg, done;

  assign is_start = (kind == KIND_START);

  // Start takes x = 0, y = r, d = 3 - 2r; next continues from the state
  always_comb begin
    cur_x  = is_start ? '0 : step_x_r;
    cur_y  = is_start ? STEP_BITS'({1'b0, radius}) : step_y_r;
    cur_d  = is_start ? DEC_BITS'(DEC_INIT) - DEC_BITS'({radius, 1'b0}) : dec_r;
    cur_ox = is_start ? ORG_BITS'(center_x) + ORG_BITS'(shift) : org_x_r;
    cur_oy = is_start ? ORG_BITS'(center_y) + ORG_BITS'(shift) : org_y_r;
  end

  always_comb begin
    x_d     = DEC_BITS'(cur_x);
    y_d     = DEC_BITS'(cur_y);
    dec_neg = cur_d[DEC_BITS-1];
    if (dec_neg) begin
      dec_nxt    = cur_d + (x_d <<< 2) + DEC_BITS'(INC_PLAIN);
      step_y_nxt = cur_y;
    end else begin
      dec_nxt    = cur_d + ((x_d - y_d) <<< 2) + DEC_BITS'(INC_DIAG);
      step_y_nxt = cur_y - STEP_BITS'(1);
    end
    step_x_nxt = cur_x + STEP_BITS'(1);
    done       = (step_x_nxt > step_y_nxt);
  end

  // A next item with no circle in progress is dropped
  assign ctl.load = go && (is_start || active_r);
  assign ctl.done = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_x_r <= '0;
      step_y_r <= '0;
      dec_r    <= '0;
      org_x_r  <= '0;
      org_y_r  <= '0;
      active_r <= 1'b0;
    end else if (ctl.load) begin
      step_x_r <= step_x_nxt;
      step_y_r <= step_y_nxt;
      dec_r    <= dec_nxt;
      org_x_r  <= cur_ox;
      org_y_r  <= cur_oy;
      active_r <= !done;
    end
  end

endmodule

### hw/rtl/mcru_serial.sv
// ----------------------------------------------------------------------------
// mcru_serial
// Step buffer and output register: one symmetric point per transfer.
// ----------------------------------------------------------------------------
module mcru_serial import mcru_pkg::*; #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  step_ctl_t                   ctl,
  input  logic signed [RADIUS_BITS:0] x,
  input  logic signed [RADIUS_BITS:0] y,
  input  logic signed [COORD_BITS:0]  ox,
  input  logic signed [COORD_BITS:0]  oy,
  output logic                        sb_free,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [COORD_BITS:0]  out_point_x,
  output logic signed [COORD_BITS:0]  out_point_y,
  output logic                        out_last_of_step,
  output logic                        out_circle_done
);

  `include "midpoint_circle_rasterizer_unit_assert.svh"

  localparam int STEP_BITS = RADIUS_BITS + 1;
  localparam int ORG_BITS  = COORD_BITS + 1;
  localparam int OUT_BITS  = COORD_BITS + 1;
  localparam int PW        = (ORG_BITS > STEP_BITS) ? ORG_BITS : STEP_BITS;

  logic                        sb_vld_r, sb_done_r;
  logic        [IDX_BITS-1:0]  sb_idx_r;
  logic signed [STEP_BITS-1:0] sb_x_r, sb_y_r;
  logic signed [ORG_BITS-1:0]  sb_ox_r, sb_oy_r;

  logic                        out_valid_r, out_last_r, out_done_r;
  logic signed [OUT_BITS-1:0]  out_px_r, out_py_r;

  logic                        out_load, sb_last;
  logic signed [STEP_BITS-1:0] a, b;
  logic signed [PW-1:0]        a_e, b_e, ox_e, oy_e, sum_x, sum_y;

  assign out_load = sb_vld_r && (!out_valid_r || out_ready);
  assign sb_last  = (sb_idx_r == LAST_IDX);
  assign sb_free  = !sb_vld_r || (out_load && sb_last);

  // idx[2] swaps x and y, idx[1] negates the x offset, idx[0] the y offset
  always_comb begin
    a     = sb_idx_r[2] ? sb_y_r : sb_x_r;
    b     = sb_idx_r[2] ? sb_x_r : sb_y_r;
    a_e   = PW'(a);
    b_e   = PW'(b);
    ox_e  = PW'(sb_ox_r);
    oy_e  = PW'(sb_oy_r);
    sum_x = sb_idx_r[1] ? ox_e - a_e : ox_e + a_e;
    sum_y = sb_idx_r[0] ? oy_e - b_e : oy_e + b_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_vld_r <= 1'b0;
      sb_idx_r <= '0;
    end else if (ctl.load) begin
      sb_vld_r <= 1'b1;
      sb_idx_r <= '0;
    end else if (out_load) begin
      sb_idx_r <= sb_idx_r + IDX_BITS'(1);
      if (sb_last) begin
        sb_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sb_x_r    <= x;
      sb_y_r    <= y;
      sb_ox_r   <= ox;
      sb_oy_r   <= oy;
      sb_done_r <= ctl.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_px_r   <= sum_x[OUT_BITS-1:0];
      out_py_r   <= sum_y[OUT_BITS-1:0];
      out_last_r <= sb_last;
      out_done_r <= sb_done_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_point_x      = out_px_r;
  assign out_point_y      = out_py_r;
  assign out_last_of_step = out_last_r;
  assign out_circle_done  = out_done_r;

  `MCRU_NEVER(a_load_over_busy, clk, rst_n, ctl.load && !sb_free, "step buffer overwritten")
  `MCRU_ASSERT(a_idx_needs_step, clk, rst_n, (sb_idx_r != '0) |-> sb_vld_r, "index without step")
  `MCRU_ASSERT(a_idx_holds, clk, rst_n, (sb_vld_r && !out_load && !ctl.load) |=> $stable(sb_idx_r), "index moved while stalled")
  `MCRU_ASSERT(a_step_retires, clk, rst_n, (out_load && sb_last && !ctl.load) |=> !sb_vld_r, "step not retired after last point")

endmodule
